[rtl/lpft_pkg.sv]
// Shared types and constants for the LRU page frame table.
package lpft_pkg;

    // Upper bounds of the per-frame fields carried along the cell chain, and port widths
    localparam int IDX_W_MAX  = 6;
    localparam int PAGE_W_MAX = 32;
    localparam int FAULT_W    = 16;
    localparam int CFG_W      = 4;
    localparam int SLOT_W     = 3;
    localparam int EV_PAGE_W  = 16;

    localparam logic [FAULT_W-1:0] FAULT_MAX = '1;

    // Controller states
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SEARCH,
        ST_COMMIT
    } t_state;

    // Running search summary, handed from cell to cell
    typedef struct packed {
        logic                  hit_found;
        logic [IDX_W_MAX-1:0]  hit_idx;
        logic [IDX_W_MAX-1:0]  hit_rank;
        logic                  empty_found;
        logic [IDX_W_MAX-1:0]  empty_idx;
        logic [IDX_W_MAX-1:0]  max_rank;
        logic [IDX_W_MAX-1:0]  max_idx;
        logic [PAGE_W_MAX-1:0] max_page;
    } t_sum;

    // Update broadcast to every cell at commit
    typedef struct packed {
        logic                  apply;
        logic [IDX_W_MAX-1:0]  slot;
        logic                  was_valid;
        logic                  write_page;
        logic [IDX_W_MAX-1:0]  limit;
        logic [PAGE_W_MAX-1:0] page;
    } t_cmd;

endpackage

[rtl/lpft_cell.sv]
// One frame cell: holds page, valid and age rank, and folds itself into the search summary.
module lpft_cell #(
    parameter int IDX       = 0,
    parameter int PAGE_BITS = 16,
    parameter int RANK_W    = 3
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic [PAGE_BITS-1:0] i_key,
    input  logic                 i_in_range,
    input  lpft_pkg::t_sum       i_sum,
    input  lpft_pkg::t_cmd       i_cmd,
    output lpft_pkg::t_sum       o_sum
);
    import lpft_pkg::*;

    logic [PAGE_BITS-1:0] r_page;
    logic                 r_valid;
    logic [RANK_W-1:0]    r_rank;
    t_sum                 r_sum;
    t_sum                 n_sum;

    logic [IDX_W_MAX-1:0] w_idx;
    logic [IDX_W_MAX-1:0] w_rank;
    logic                 w_hit;
    logic                 w_empty;

    assign w_idx   = IDX_W_MAX'(IDX);
    assign w_rank  = IDX_W_MAX'(r_rank);
    assign w_hit   = i_in_range & r_valid & (r_page == i_key);
    assign w_empty = i_in_range & ~r_valid;

    // Fold this frame into the summary from the left neighbour
    always_comb begin
        n_sum = i_sum;
        if (w_hit && !i_sum.hit_found) begin
            n_sum.hit_found = 1'b1;
            n_sum.hit_idx   = w_idx;
            n_sum.hit_rank  = w_rank;
        end
        if (w_empty && !i_sum.empty_found) begin
            n_sum.empty_found = 1'b1;
            n_sum.empty_idx   = w_idx;
        end
        // first frame seeds the oldest choice; strictly older wins, so the lowest index
        // keeps a tie
        if (i_in_range && ((IDX == 0) || (w_rank > i_sum.max_rank))) begin
            n_sum.max_rank = w_rank;
            n_sum.max_idx  = w_idx;
            n_sum.max_page = PAGE_W_MAX'(r_page);
        end
    end

    always_ff @(posedge i_clk) begin
        r_sum <= n_sum;
    end

    assign o_sum = r_sum;

    // Frame state: the chosen frame becomes youngest, younger frames age by one
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_rank  <= '0;
        end else if (i_cmd.apply) begin
            if (i_cmd.slot == w_idx) begin
                r_valid <= 1'b1;
                r_rank  <= '0;
            end else if (r_valid && (!i_cmd.was_valid || (w_rank < i_cmd.limit))) begin
                r_rank <= r_rank + RANK_W'(1);
            end
        end
    end

    // Page store, written only when the frame is (re)filled
    always_ff @(posedge i_clk) begin
        if (i_cmd.apply && i_cmd.write_page && (i_cmd.slot == w_idx)) begin
            r_page <= i_cmd.page[PAGE_BITS-1:0];
        end
    end

endmodule

[rtl/lru_page_frame_table_top.sv]
// LRU page frame table: top level with the search controller and the cell chain.
//
// Usage:
//   Input channel (i_in_valid / o_in_stall) carries one page reference per item.
//   Output channel (o_out_valid / i_out_stall) returns one result per item:
//   hit flag, frame slot, evicted page (zero when none) and the fault count.
//   i_cfg_we / i_cfg_wdata set the number of frames managed; write only while idle.
//   Each item is taken in the idle state; the search summary then ripples through
//   the registered chain of frame cells (one cell per cycle), and a commit step
//   updates the frames and loads the output register.
//   A new item is taken only once the previous one has committed, so the block
//   does not take a new page reference before it is through with the last one.
//   Reset (synchronous, active low) empties every frame, clears the fault count
//   and sets the frame count to eight.
//   If the receiver stalls, the result holds in the output register; the commit
//   of the next item waits until that register is free.
module lru_page_frame_table_top #(
    parameter int MAX_FRAMES = 8,
    parameter int PAGE_BITS  = 16
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    // configuration
    input  logic                             i_cfg_we,
    input  logic [lpft_pkg::CFG_W-1:0]       i_cfg_wdata,
    // input channel
    input  logic                             i_in_valid,
    output logic                             o_in_stall,
    input  logic [PAGE_BITS-1:0]             i_page_number,
    // output channel
    output logic                             o_out_valid,
    input  logic                             i_out_stall,
    output logic                             o_hit,
    output logic [lpft_pkg::SLOT_W-1:0]      o_slot,
    output logic                             o_evicted_valid,
    output logic [lpft_pkg::EV_PAGE_W-1:0]   o_evicted_page,
    output logic [lpft_pkg::FAULT_W-1:0]     o_fault_count
);
    import lpft_pkg::*;

    localparam int IW     = (MAX_FRAMES > 1) ? $clog2(MAX_FRAMES) : 1;
    localparam int RANK_W = IW;
    localparam int NW     = 8;

    // Configuration register
    logic [CFG_W-1:0] r_frames_in_use;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_frames_in_use <= CFG_W'(8);
        end else if (i_cfg_we) begin
            r_frames_in_use <= i_cfg_wdata;
        end
    end

    // Effective frame count: zero acts as one, clamp to MAX_FRAMES
    logic [NW-1:0] w_cfg_ext;
    logic [NW-1:0] w_n_eff;

    assign w_cfg_ext = NW'(r_frames_in_use);

    always_comb begin
        if (w_cfg_ext == '0) begin
            w_n_eff = NW'(1);
        end else if (w_cfg_ext > NW'(MAX_FRAMES)) begin
            w_n_eff = NW'(MAX_FRAMES);
        end else begin
            w_n_eff = w_cfg_ext;
        end
    end

    // Controller
    t_state            r_state;
    t_state            n_state;
    logic [IW-1:0]     r_cnt;
    logic [PAGE_BITS-1:0] r_key;
    logic              w_take;
    logic              w_can_load;
    logic              w_commit;
    logic              w_search_done;

    assign w_take        = i_in_valid & ~o_in_stall;
    assign w_can_load    = ~o_out_valid | ~i_out_stall;
    assign w_search_done = (r_cnt == IW'(MAX_FRAMES - 1));

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (w_take) n_state = ST_SEARCH;
            end
            ST_SEARCH: begin
                if (w_search_done) n_state = ST_COMMIT;
            end
            ST_COMMIT: begin
                if (w_can_load) n_state = ST_IDLE;
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // state outputs
    always_comb begin
        o_in_stall = 1'b1;
        w_commit   = 1'b0;
        case (r_state)
            ST_IDLE:   o_in_stall = 1'b0;
            ST_SEARCH: o_in_stall = 1'b1;
            ST_COMMIT: w_commit   = w_can_load;
            default:   o_in_stall = 1'b1;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_cnt   <= '0;
        end else begin
            r_state <= n_state;
            if (r_state == ST_SEARCH) begin
                r_cnt <= r_cnt + IW'(1);
            end else begin
                r_cnt <= '0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_take) r_key <= i_page_number;
    end

    // Cell chain
    t_sum w_sum [MAX_FRAMES+1];
    t_sum w_fin;
    t_cmd w_cmd;

    assign w_sum[0] = '0;
    assign w_fin    = w_sum[MAX_FRAMES];

    for (genvar g = 0; g < MAX_FRAMES; g++) begin : g_cell
        logic w_in_range;
        assign w_in_range = (NW'(g) < w_n_eff);

        lpft_cell #(
            .IDX       (g),
            .PAGE_BITS (PAGE_BITS),
            .RANK_W    (RANK_W)
        ) u_cell (
            .i_clk      (i_clk),
            .i_rst_n    (i_rst_n),
            .i_key      (r_key),
            .i_in_range (w_in_range),
            .i_sum      (w_sum[g]),
            .i_cmd      (w_cmd),
            .o_sum      (w_sum[g+1])
        );
    end

    // Decision from the completed summary
    logic                 w_hit;
    logic                 w_evict;
    logic [IDX_W_MAX-1:0] w_slot;

    assign w_hit   = w_fin.hit_found;
    assign w_evict = ~w_fin.hit_found & ~w_fin.empty_found;

    always_comb begin
        if (w_fin.hit_found) begin
            w_slot = w_fin.hit_idx;
        end else if (w_fin.empty_found) begin
            w_slot = w_fin.empty_idx;
        end else begin
            w_slot = w_fin.max_idx;
        end
    end

    always_comb begin
        w_cmd.apply      = w_commit;
        w_cmd.slot       = w_slot;
        w_cmd.was_valid  = w_hit | w_evict;
        w_cmd.write_page = ~w_hit;
        w_cmd.limit      = w_hit ? w_fin.hit_rank : w_fin.max_rank;
        w_cmd.page       = PAGE_W_MAX'(r_key);
    end

    // Fault counter, saturating
    logic [FAULT_W-1:0] r_faults;
    logic [FAULT_W-1:0] n_faults;

    assign n_faults = (!w_hit && (r_faults != FAULT_MAX)) ? r_faults + FAULT_W'(1) : r_faults;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_faults <= '0;
        end else if (w_commit) begin
            r_faults <= n_faults;
        end
    end

    // Output register
    logic r_out_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_commit) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_commit) begin
            o_hit           <= w_hit;
            o_slot          <= w_slot[SLOT_W-1:0];
            o_evicted_valid <= w_evict;
            o_evicted_page  <= w_evict ? w_fin.max_page[EV_PAGE_W-1:0] : '0;
            o_fault_count   <= n_faults;
        end
    end

    assign o_out_valid = r_out_valid;

endmodule

[tb/sv/lru_page_frame_table_top_test.sv]
// Self-checking testbench for the LRU page frame table: directed table and random mix.
`timescale 1ns / 100ps

module lru_page_frame_table_top_test;

    import lpft_pkg::*;

    localparam int NFR         = 8;
    localparam int PAGE_W      = 16;
    localparam int RAND_ITEMS  = 1000;
    localparam int CYCLE_LIMIT = 3_000_000;
    localparam int DIR_LEN     = 26;

    // One result item as the block reports it
    typedef struct packed {
        logic                 hit;
        logic [SLOT_W-1:0]    slot;
        logic                 ev_valid;
        logic [EV_PAGE_W-1:0] ev_page;
        logic [FAULT_W-1:0]   faults;
    } t_lookup_res;

    typedef enum logic {
        ROW_PAGE,
        ROW_FRAMES
    } t_row_kind;

    // Directed row: a page reference or a frame count write
    typedef struct packed {
        t_row_kind   kind;
        logic [15:0] value;
        logic        typed;
        t_lookup_res want;
    } t_dir_row;

    // DUT connections; the driven inputs are known from time zero
    logic                  i_clk           = 1'b0;
    logic                  i_rst_n         = 1'b0;
    logic                  i_cfg_we        = 1'b0;
    logic [CFG_W-1:0]      i_cfg_wdata     = '0;
    logic                  i_in_valid      = 1'b0;
    logic                  o_in_stall;
    logic [PAGE_W-1:0]     i_page_number   = '0;
    logic                  o_out_valid;
    logic                  i_out_stall     = 1'b0;
    logic                  o_hit;
    logic [SLOT_W-1:0]     o_slot;
    logic                  o_evicted_valid;
    logic [EV_PAGE_W-1:0]  o_evicted_page;
    logic [FAULT_W-1:0]    o_fault_count;

    // Shadow frame table
    logic [PAGE_W-1:0]     pg_tab  [NFR];
    logic                  vld_tab [NFR] = '{default: 1'b0};
    logic [2:0]            age_tab [NFR] = '{default: 3'd0};
    logic [FAULT_W-1:0]    fault_tally   = '0;
    logic [CFG_W-1:0]      frame_cfg     = 4'd8;

    t_lookup_res           pending [$];
    int                    mismatches    = 0;
    int unsigned           cycle_count   = 0;
    bit                    src_idle_on   = 1'b1;
    bit                    sink_idle_on  = 1'b1;
    int                    hold_req      = 0;

    // Directed stimulus; typed results only where they are obvious
    t_dir_row dir_rows [DIR_LEN] = '{
        '{ROW_PAGE,   16'h0000, 1'b1, '{1'b0, 3'd0, 1'b0, 16'h0000, 16'd1}},
        '{ROW_PAGE,   16'hFFFF, 1'b1, '{1'b0, 3'd1, 1'b0, 16'h0000, 16'd2}},
        '{ROW_PAGE,   16'h0000, 1'b1, '{1'b1, 3'd0, 1'b0, 16'h0000, 16'd2}},
        '{ROW_PAGE,   16'hFFFF, 1'b1, '{1'b1, 3'd1, 1'b0, 16'h0000, 16'd2}},
        '{ROW_FRAMES, 16'd0,    1'b0, '0},
        '{ROW_PAGE,   16'h1234, 1'b1, '{1'b0, 3'd0, 1'b1, 16'h0000, 16'd3}},
        '{ROW_PAGE,   16'h1234, 1'b0, '0},
        '{ROW_PAGE,   16'hFFFF, 1'b0, '0},
        '{ROW_FRAMES, 16'd15,   1'b0, '0},
        '{ROW_PAGE,   16'hFFFF, 1'b0, '0},
        '{ROW_PAGE,   16'h00FF, 1'b0, '0},
        '{ROW_FRAMES, 16'd8,    1'b0, '0},
        '{ROW_PAGE,   16'h8000, 1'b0, '0},
        '{ROW_PAGE,   16'h0001, 1'b0, '0},
        '{ROW_PAGE,   16'h7FFF, 1'b0, '0},
        '{ROW_PAGE,   16'hAAAA, 1'b0, '0},
        '{ROW_PAGE,   16'h5555, 1'b0, '0},
        '{ROW_PAGE,   16'h8001, 1'b0, '0},
        '{ROW_FRAMES, 16'd3,    1'b0, '0},
        '{ROW_PAGE,   16'h5555, 1'b0, '0},
        '{ROW_PAGE,   16'h0002, 1'b0, '0},
        '{ROW_FRAMES, 16'd1,    1'b0, '0},
        '{ROW_PAGE,   16'h0002, 1'b0, '0},
        '{ROW_FRAMES, 16'd8,    1'b0, '0},
        '{ROW_PAGE,   16'h5555, 1'b0, '0},
        '{ROW_PAGE,   16'hAAAA, 1'b0, '0}
    };

    lru_page_frame_table_top #(
        .MAX_FRAMES (NFR),
        .PAGE_BITS  (PAGE_W)
    ) dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_wdata     (i_cfg_wdata),
        .i_in_valid      (i_in_valid),
        .o_in_stall      (o_in_stall),
        .i_page_number   (i_page_number),
        .o_out_valid     (o_out_valid),
        .i_out_stall     (i_out_stall),
        .o_hit           (o_hit),
        .o_slot          (o_slot),
        .o_evicted_valid (o_evicted_valid),
        .o_evicted_page  (o_evicted_page),
        .o_fault_count   (o_fault_count)
    );

    always #1 i_clk = ~i_clk;

    // Frame s becomes most recent; valid frames younger than it age by one
    function automatic void promote(input int s, input bit was_valid);
        logic [3:0] lim;
        int         i;
        lim = was_valid ? {1'b0, age_tab[s]} : 4'hF;
        for (i = 0; i < NFR; i++) begin
            if (i != s && vld_tab[i] && age_tab[i] < lim)
                age_tab[i] = age_tab[i] + 3'd1;
        end
        age_tab[s] = 3'd0;
    endfunction

    // LRU lookup on the shadow table; updates it and returns the result item
    function automatic t_lookup_res lru_lookup(input logic [PAGE_W-1:0] page);
        t_lookup_res r;
        int          n;
        int          i;
        int          victim;
        bit          found;
        logic [2:0]  best;
        r      = '0;
        n      = (frame_cfg == 0) ? 1 : (frame_cfg > NFR) ? NFR : int'(frame_cfg);
        victim = 0;
        found  = 1'b0;
        // lowest matching frame among the managed ones
        for (i = 0; i < n; i++) begin
            if (!found && vld_tab[i] && pg_tab[i] == page) begin
                found  = 1'b1;
                victim = i;
            end
        end
        if (found) begin
            r.hit = 1'b1;
            promote(victim, 1'b1);
        end else begin
            // lowest empty frame first, else the oldest one
            for (i = 0; i < n; i++) begin
                if (!found && !vld_tab[i]) begin
                    found  = 1'b1;
                    victim = i;
                end
            end
            if (found) begin
                vld_tab[victim] = 1'b1;
                pg_tab[victim]  = page;
                promote(victim, 1'b0);
            end else begin
                best = 3'd0;
                for (i = 0; i < n; i++) begin
                    if (age_tab[i] > best) begin
                        best   = age_tab[i];
                        victim = i;
                    end
                end
                r.ev_valid     = 1'b1;
                r.ev_page      = pg_tab[victim];
                pg_tab[victim] = page;
                promote(victim, 1'b1);
            end
            if (fault_tally != FAULT_MAX)
                fault_tally = fault_tally + 1'b1;
        end
        r.slot   = victim[SLOT_W-1:0];
        r.faults = fault_tally;
        return r;
    endfunction

    // Offer one page reference, log its expected result, then maybe idle
    task automatic offer_page(input logic [PAGE_W-1:0] page, input logic typed,
                              input t_lookup_res want);
        t_lookup_res model_res;
        int          gap;
        i_in_valid    <= 1'b1;
        i_page_number <= page;
        do @(posedge i_clk); while (o_in_stall);
        model_res = lru_lookup(page);
        pending.push_back(typed ? want : model_res);
        gap = src_idle_on ? $urandom_range(0, 14) : 0;
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    // Frame count write, only once every result is back
    task automatic set_frames(input logic [CFG_W-1:0] v);
        i_in_valid <= 1'b0;
        while (pending.size() != 0) @(posedge i_clk);
        i_cfg_wdata <= v;
        i_cfg_we    <= 1'b1;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
        frame_cfg = v;
    endtask

    task automatic check_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
        if (got !== want) begin
            mismatches++;
            if (mismatches <= 10)
                $display("%0t: %s mismatch, expected %0h, got %0h", $time, name, want, got);
        end
    endtask

    // Result sink: random back-pressure, plus one long hold when asked
    initial begin : result_sink
        int wait_cycles;
        wait (i_rst_n === 1'b1);
        @(posedge i_clk);
        forever begin
            if (hold_req > 0) begin
                wait_cycles = hold_req;
                hold_req    = 0;
            end else begin
                wait_cycles = sink_idle_on ? $urandom_range(0, 14) : 0;
            end
            if (wait_cycles > 0) begin
                i_out_stall <= 1'b1;
                repeat (wait_cycles) @(posedge i_clk);
                i_out_stall <= 1'b0;
            end
            do @(posedge i_clk); while (o_out_valid !== 1'b1);
        end
    end

    // Compare each accepted result with the oldest expectation
    always @(posedge i_clk) begin : result_check
        t_lookup_res want;
        if (i_rst_n && o_out_valid === 1'b1 && !i_out_stall) begin
            if (pending.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("%0t: result item with nothing expected", $time);
            end else begin
                want = pending.pop_front();
                check_field("hit",           want.hit,      o_hit);
                check_field("slot",          want.slot,     o_slot);
                check_field("evicted_valid", want.ev_valid, o_evicted_valid);
                check_field("evicted_page",  want.ev_page,  o_evicted_page);
                check_field("fault_count",   want.faults,   o_fault_count);
            end
        end
    end

    // Watchdog
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

    initial begin : stimulus
        logic [PAGE_W-1:0] ws [16];
        logic [PAGE_W-1:0] page;
        logic [CFG_W-1:0]  cfg;
        int                ws_len;
        int                eff;
        int                burst;
        int                phase;
        int                rand_items;
        int                k;
        int                r;

        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed table
        for (r = 0; r < DIR_LEN; r++) begin
            if (dir_rows[r].kind == ROW_FRAMES)
                set_frames(dir_rows[r].value[CFG_W-1:0]);
            else
                offer_page(dir_rows[r].value, dir_rows[r].typed, dir_rows[r].want);
        end

        // random phases: frame count, gap modes and working set vary per phase
        phase      = 0;
        rand_items = 0;
        ws_len     = 1;
        while (rand_items < RAND_ITEMS) begin
            case (phase)
                0:       cfg = 4'd1;
                1:       cfg = 4'd8;
                2:       cfg = 4'd0;
                3:       cfg = 4'd15;
                default: cfg = CFG_W'($urandom_range(0, 15));
            endcase
            set_frames(cfg);
            eff = (cfg == 0) ? 1 : (cfg > NFR) ? NFR : int'(cfg);
            src_idle_on  = ($urandom_range(0, 3) != 0);
            sink_idle_on = ($urandom_range(0, 3) != 0);
            if (phase == 5) begin
                src_idle_on  = 1'b0;
                sink_idle_on = 1'b0;
            end
            // long hold at the sink while references keep coming
            if (phase == 6) begin
                src_idle_on = 1'b0;
                hold_req    = 300;
            end
            // keeping the old set now and then leaves stale copies behind
            if (phase == 0 || $urandom_range(0, 1) == 0) begin
                ws_len = eff + $urandom_range(0, 4);
                for (k = 0; k < ws_len; k++)
                    ws[k] = PAGE_W'($urandom_range(0, 16'hFFFF));
            end
            burst = $urandom_range(40, 90);
            repeat (burst) begin
                if ($urandom_range(0, 4) == 0)
                    page = PAGE_W'($urandom_range(0, 16'hFFFF));
                else
                    page = ws[$urandom_range(0, ws_len - 1)];
                offer_page(page, 1'b0, '0);
            end
            rand_items += burst;
            phase++;
        end

        i_in_valid <= 1'b0;
        while (pending.size() != 0) @(posedge i_clk);
        repeat (NFR + 4) @(posedge i_clk);
        if (mismatches == 0 && pending.size() == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule
